// ===== rtl/core/sor_pkg.sv =====
// Shared types and constants for the sensor outlier replacer.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none
package sor_pkg;

	localparam int NS   = 4;   // sensors in one set
	localparam int RW   = 32;  // reading width, signed Q16.16
	localparam int CW   = 16;  // coefficient width, unsigned Q4.12
	localparam int PW   = 2 * CW; // coefficient times threshold, Q8.24
	localparam int AMW  = 34;  // |4r - sum|
	localparam int MNW  = 36;  // sum of |4r - sum|, sixteen times the mean deviation
	localparam int MDW  = 34;  // twice the median absolute deviation
	localparam int XW   = 72;  // width of the scaled limit compare
	localparam int DCW  = 3;   // dead count width
	localparam int IDXW = 2;   // register index width

	// register indexes
	localparam logic [IDXW-1:0] REG_MED_COEFF = 2'd0;
	localparam logic [IDXW-1:0] REG_MEAN_COEFF = 2'd1;
	localparam logic [IDXW-1:0] REG_THRESHOLD = 2'd2;

	// reset values
	localparam logic [CW-1:0] MED_COEFF_RST = 16'd6073;
	localparam logic [CW-1:0] MEAN_COEFF_RST = 16'd5134;
	localparam logic [CW-1:0] THRESHOLD_RST = 16'd14336;
	localparam logic [PW-1:0] PMED_RST = PW'(MED_COEFF_RST) * PW'(THRESHOLD_RST);
	localparam logic [PW-1:0] PMEAN_RST = PW'(MEAN_COEFF_RST) * PW'(THRESHOLD_RST);

	typedef logic signed [RW-1:0] rd_t;

	// after median stage
	typedef struct {
		rd_t              r[NS];
		logic [NS-1:0]    zero;
		logic [DCW-1:0]   dead;
		rd_t              med;
		logic [AMW-1:0]   am[NS];
	} med_res_t;

	// after deviation stages
	typedef struct {
		rd_t              r[NS];
		logic [NS-1:0]    zero;
		logic [DCW-1:0]   dead;
		rd_t              med;
		logic [RW-1:0]    ad[NS];
		logic [MDW-1:0]   mad2;
		logic [MNW-1:0]   mean16;
	} dev_res_t;

	// final result
	typedef struct {
		rd_t              cleaned[NS];
		logic [NS-1:0]    mask;
		logic [DCW-1:0]   dead;
	} out_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/sensor_outlier_replacer.sv =====
// Top level of the sensor outlier replacer: stream ports, registers, six-stage pipeline.
// Depends on sor_pkg, sor_median, sor_dev and sor_judge.
//
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  four readings, one set per transfer
// m_*      out  m_tvalid/m_tready  cleaned readings, reliability mask, dead count
// cfg_*    in   cfg_wr_en          register writes, no read-back
//
// One set per cycle sustained while the output sink is ready; each set passes through
// six pipeline registers from input transfer to output: two for the median,
// two for the deviations, two for the split multiply and compare.
// Each stage holds its own valid bit; a stage takes new data when it is empty or
// its successor moves, so bubbles close up and a stall loses nothing.
// Reset clears valid bits and loads register defaults and their products.
`default_nettype none
module sensor_outlier_replacer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // reading_0, reading_1, reading_2, reading_3
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [135:0]      m_tdata,   // cleaned_0..3, reliable_mask, dead_count, pad
	input  wire logic         cfg_wr_en,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [15:0]  cfg_wdata
);
	logic [sor_pkg::CW-1:0] med_coeff_q, mean_coeff_q, thr_q;
	logic [sor_pkg::PW-1:0] pmed_q, pmean_q;
	sor_pkg::rd_t rin[sor_pkg::NS];
	logic med_valid, med_ready, dev_valid, dev_ready;
	sor_pkg::med_res_t med_res;
	sor_pkg::dev_res_t dev_res;
	sor_pkg::out_res_t out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			med_coeff_q <= sor_pkg::MED_COEFF_RST;
			mean_coeff_q <= sor_pkg::MEAN_COEFF_RST;
			thr_q <= sor_pkg::THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				sor_pkg::REG_MED_COEFF: med_coeff_q <= cfg_wdata;
				sor_pkg::REG_MEAN_COEFF: mean_coeff_q <= cfg_wdata;
				sor_pkg::REG_THRESHOLD: thr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// coefficient times threshold, Q8.24
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmed_q <= sor_pkg::PMED_RST;
			pmean_q <= sor_pkg::PMEAN_RST;
		end else begin
			pmed_q <= sor_pkg::PW'(med_coeff_q) * sor_pkg::PW'(thr_q);
			pmean_q <= sor_pkg::PW'(mean_coeff_q) * sor_pkg::PW'(thr_q);
		end
	end

	// unpack readings
	always_comb begin
		for (int i = 0; i < sor_pkg::NS; i++) begin
			rin[i] = s_tdata[i*sor_pkg::RW +: sor_pkg::RW];
		end
	end

	sor_median u_median (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_r(rin),
		.out_valid(med_valid), .out_ready(med_ready), .out_res(med_res)
	);

	sor_dev u_dev (
		.clk(clk), .arst_n(arst_n),
		.in_valid(med_valid), .in_ready(med_ready), .in_res(med_res),
		.out_valid(dev_valid), .out_ready(dev_ready), .out_res(dev_res)
	);

	sor_judge u_judge (
		.clk(clk), .arst_n(arst_n),
		.in_valid(dev_valid), .in_ready(dev_ready), .in_res(dev_res),
		.pmed(pmed_q), .pmean(pmean_q),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(out_res)
	);

	// pack result
	assign m_tdata = {1'b0, out_res.dead, out_res.mask, out_res.cleaned[3],
		out_res.cleaned[2], out_res.cleaned[1], out_res.cleaned[0]};

`ifndef NO_ASSERTIONS
	// a ready sink lets the whole pipeline move
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output sink ready");

	// every dead reading is flagged unreliable
	a_dead_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($countones(~m_tdata[131:128]) >= 32'(m_tdata[134:132])))
		else $error("fewer unreliable flags than dead readings");

	// dead count never exceeds sensor count
	a_dead_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[134:132] <= 3'd4))
		else $error("dead count out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/sor_median.sv =====
// Stages 1-2: dead detection, partial sort, median and mean deviation terms.
// Depends on sor_pkg.
`default_nettype none
module sor_median (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sor_pkg::rd_t    in_r[sor_pkg::NS],
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sor_pkg::med_res_t    out_res
);
	localparam int RW_SUM = sor_pkg::RW + 2;

	logic v_s1, v_s2, rdy1, rdy2;
	sor_pkg::rd_t r_s1[sor_pkg::NS];
	logic [sor_pkg::NS-1:0] zero_s1;
	logic [sor_pkg::DCW-1:0] dead_s1;
	logic signed [RW_SUM-1:0] sum_s1;
	sor_pkg::rd_t lo1_s1, hi1_s1, lo2_s1, hi2_s1, fl_s1, ll_s1;
	sor_pkg::med_res_t res_s2;

	logic [sor_pkg::NS-1:0] zero_c;
	logic [sor_pkg::DCW-1:0] dead_c;
	logic signed [RW_SUM-1:0] sum_c;
	sor_pkg::rd_t fl_c, ll_c;
	sor_pkg::rd_t ma, mb, pa, pb;
	logic signed [sor_pkg::RW:0] avg_sum;
	sor_pkg::rd_t med_c;
	logic signed [sor_pkg::MNW-1:0] amd[sor_pkg::NS];
	logic [sor_pkg::AMW-1:0] am_c[sor_pkg::NS];

	assign rdy2 = !v_s2 || out_ready;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = v_s2;
	assign out_res = res_s2;

	// stage 1 logic: zero flags, count, sum, first and last live reading
	always_comb begin
		dead_c = '0;
		sum_c = '0;
		fl_c = '0;
		ll_c = '0;
		for (int i = 0; i < sor_pkg::NS; i++) begin
			zero_c[i] = (in_r[i] == '0);
			dead_c = dead_c + sor_pkg::DCW'(zero_c[i]);
			sum_c = sum_c + RW_SUM'(in_r[i]);
			if (!zero_c[i]) ll_c = in_r[i];
		end
		for (int i = sor_pkg::NS - 1; i >= 0; i--) begin
			if (!zero_c[i]) fl_c = in_r[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (rdy1) v_s1 <= in_valid;
	end

	// first compare-swap layer on the pairs
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			r_s1 <= in_r;
			zero_s1 <= zero_c;
			dead_s1 <= dead_c;
			sum_s1 <= sum_c;
			lo1_s1 <= (in_r[0] < in_r[1]) ? in_r[0] : in_r[1];
			hi1_s1 <= (in_r[0] < in_r[1]) ? in_r[1] : in_r[0];
			lo2_s1 <= (in_r[2] < in_r[3]) ? in_r[2] : in_r[3];
			hi2_s1 <= (in_r[2] < in_r[3]) ? in_r[3] : in_r[2];
			fl_s1 <= fl_c;
			ll_s1 <= ll_c;
		end
	end

	// stage 2 logic: middle pair (first and last live reading when half or more are dead), floor average, |4r - sum|
	always_comb begin
		ma = (lo1_s1 > lo2_s1) ? lo1_s1 : lo2_s1;
		mb = (hi1_s1 < hi2_s1) ? hi1_s1 : hi2_s1;
		if (dead_s1 >= sor_pkg::DCW'(sor_pkg::NS / 2)) begin
			pa = fl_s1;
			pb = ll_s1;
		end else begin
			pa = ma;
			pb = mb;
		end
		avg_sum = (sor_pkg::RW + 1)'(pa) + (sor_pkg::RW + 1)'(pb);
		med_c = avg_sum[sor_pkg::RW:1];
		for (int i = 0; i < sor_pkg::NS; i++) begin
			amd[i] = (sor_pkg::MNW'(r_s1[i]) <<< 2) - sor_pkg::MNW'(sum_s1);
			am_c[i] = amd[i][sor_pkg::MNW-1] ? sor_pkg::AMW'(-amd[i])
				: sor_pkg::AMW'(amd[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (rdy2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			res_s2.r <= r_s1;
			res_s2.zero <= zero_s1;
			res_s2.dead <= dead_s1;
			res_s2.med <= med_c;
			res_s2.am <= am_c;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sor_dev.sv =====
// Stages 3-4: absolute deviations, mean deviation sum and median absolute deviation.
// Depends on sor_pkg.
`default_nettype none
module sor_dev (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sor_pkg::med_res_t in_res,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sor_pkg::dev_res_t      out_res
);
	logic v_s3, v_s4, rdy3, rdy4;
	sor_pkg::med_res_t m_s3;
	logic [sor_pkg::RW-1:0] ad_s3[sor_pkg::NS];
	logic [sor_pkg::MNW-1:0] mean16_s3;
	sor_pkg::dev_res_t res_s4;

	logic signed [sor_pkg::RW:0] df[sor_pkg::NS];
	logic [sor_pkg::RW-1:0] ad_c[sor_pkg::NS];
	logic [sor_pkg::MNW-1:0] mean_c;
	logic [sor_pkg::RW-1:0] l1, h1, l2, h2, da, db;

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign in_ready = rdy3;
	assign out_valid = v_s4;
	assign out_res = res_s4;

	// stage 3 logic: |r - med| and the mean deviation sum
	always_comb begin
		mean_c = '0;
		for (int i = 0; i < sor_pkg::NS; i++) begin
			df[i] = (sor_pkg::RW + 1)'(in_res.r[i]) - (sor_pkg::RW + 1)'(in_res.med);
			ad_c[i] = df[i][sor_pkg::RW] ? sor_pkg::RW'(-df[i]) : sor_pkg::RW'(df[i]);
			mean_c = mean_c + sor_pkg::MNW'(in_res.am[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (rdy3) v_s3 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && in_valid) begin
			m_s3 <= in_res;
			ad_s3 <= ad_c;
			mean16_s3 <= mean_c;
		end
	end

	// stage 4 logic: middle two deviations summed
	always_comb begin
		l1 = (ad_s3[0] < ad_s3[1]) ? ad_s3[0] : ad_s3[1];
		h1 = (ad_s3[0] < ad_s3[1]) ? ad_s3[1] : ad_s3[0];
		l2 = (ad_s3[2] < ad_s3[3]) ? ad_s3[2] : ad_s3[3];
		h2 = (ad_s3[2] < ad_s3[3]) ? ad_s3[3] : ad_s3[2];
		da = (l1 > l2) ? l1 : l2;
		db = (h1 < h2) ? h1 : h2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (rdy4) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			res_s4.r <= m_s3.r;
			res_s4.zero <= m_s3.zero;
			res_s4.dead <= m_s3.dead;
			res_s4.med <= m_s3.med;
			res_s4.ad <= ad_s3;
			res_s4.mad2 <= sor_pkg::MDW'(da) + sor_pkg::MDW'(db);
			res_s4.mean16 <= mean16_s3;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sor_judge.sv =====
// Stages 5-6: scaled deviation limit as partial products, outlier test, replacement.
// Depends on sor_pkg.
`default_nettype none
module sor_judge (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire sor_pkg::dev_res_t         in_res,
	input  wire logic [sor_pkg::PW-1:0]    pmed,
	input  wire logic [sor_pkg::PW-1:0]    pmean,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output sor_pkg::out_res_t              out_res
);
	localparam int LOW = 32;
	localparam int HIW = sor_pkg::MNW - LOW;

	logic v_s5, v_s6, rdy5, rdy6;
	sor_pkg::dev_res_t d_s5;
	logic use_mad_s5, none_s5;
	logic [sor_pkg::PW+LOW-1:0] pplo_s5;
	logic [sor_pkg::PW+HIW-1:0] pphi_s5;
	sor_pkg::out_res_t res_s6;

	logic use_mad_c;
	logic [sor_pkg::PW-1:0] p_c;
	logic [sor_pkg::MNW-1:0] m_c;
	logic [sor_pkg::XW-1:0] lim, lhs;
	logic bad;
	sor_pkg::out_res_t res_c;

	assign rdy6 = !v_s6 || out_ready;
	assign rdy5 = !v_s5 || rdy6;
	assign in_ready = rdy5;
	assign out_valid = v_s6;
	assign out_res = res_s6;

	// stage 5 logic: pick the deviation in use, split multiply
	always_comb begin
		use_mad_c = (in_res.mad2 != '0);
		p_c = use_mad_c ? pmed : pmean;
		m_c = use_mad_c ? sor_pkg::MNW'(in_res.mad2) : in_res.mean16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (rdy5) v_s5 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy5 && in_valid) begin
			d_s5 <= in_res;
			use_mad_s5 <= use_mad_c;
			none_s5 <= !use_mad_c && (in_res.mean16 == '0);
			pplo_s5 <= (sor_pkg::PW + LOW)'(p_c) * (sor_pkg::PW + LOW)'(m_c[LOW-1:0]);
			pphi_s5 <= (sor_pkg::PW + HIW)'(p_c) * (sor_pkg::PW + HIW)'(m_c[sor_pkg::MNW-1:LOW]);
		end
	end

	// stage 6 logic: |d| << 28 against the limit, median taken on outliers
	always_comb begin
		lim = sor_pkg::XW'(pplo_s5) + (sor_pkg::XW'(pphi_s5) << LOW);
		if (use_mad_s5) lim = lim << 3;
		res_c.dead = d_s5.dead;
		res_c.mask = '0;
		for (int i = 0; i < sor_pkg::NS; i++) begin
			lhs = sor_pkg::XW'(d_s5.ad[i]) << 28;
			bad = d_s5.zero[i] || (!none_s5 && (lhs > lim));
			res_c.cleaned[i] = bad ? d_s5.med : d_s5.r[i];
			res_c.mask[i] = !bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (rdy6) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) res_s6 <= res_c;
	end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for sensor_outlier_replacer: directed table, then random sensor sets.
// Depends on sor_pkg and the RTL under rtl/core; an internal predictor or a typed expectation checks every result.
`default_nettype none
module tb_top;

	typedef struct packed {
		logic [2:0]       dead;
		logic [3:0]       mask;
		logic [3:0][31:0] cleaned;
	} clean_set_t;

	typedef struct packed {
		logic [3:0][31:0] rd;
		bit               typed;
		clean_set_t       res;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;    // reading_0, reading_1, reading_2, reading_3
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;         // cleaned_0..3, reliable_mask, dead_count, pad
	logic         cfg_wr_en = 1'b0;
	logic [1:0]   cfg_addr = '0;
	logic [15:0]  cfg_wdata = '0;

	// predictor copy of the registers
	logic [15:0] med_coeff = sor_pkg::MED_COEFF_RST;
	logic [15:0] mean_coeff = sor_pkg::MEAN_COEFF_RST;
	logic [15:0] thresh = sor_pkg::THRESHOLD_RST;

	clean_set_t pending_sets[$];
	int         n_fail = 0;
	int         stall_left = 0;

	sensor_outlier_replacer DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint unsigned abs_diff(longint a, longint b);
		return (a >= b) ? longint'(a - b) : longint'(b - a);
	endfunction

	// expected cleaned set for one input set under the current registers
	function automatic clean_set_t clean_set(logic [3:0][31:0] rd);
		clean_set_t          res;
		longint              r[4], w[4], t, med, sum;
		longint unsigned     dv[4], ut, ad, mad2, mean16, pmed, pmean;
		bit [127:0]          lhs, rhs;
		int                  dead, n, i, j;
		bit                  bad;
		sum = 0; dead = 0; n = 0; mean16 = 0;
		for (i = 0; i < 4; i++) begin
			r[i] = longint'(signed'(rd[i]));
			sum += r[i];
			if (r[i] == 0) dead++;
			else begin
				w[n] = r[i];
				n++;
			end
		end
		// fewer than two dead: median over every reading, zeros included
		if (dead < 2) begin
			for (i = 0; i < 4; i++) w[i] = r[i];
			n = 4;
		end
		for (i = 1; i < n; i++) begin
			t = w[i];
			for (j = i; j > 0 && w[j-1] > t; j--) w[j] = w[j-1];
			w[j] = t;
		end
		if (n == 0) med = 0;
		else if (n % 2) med = w[n/2];
		else med = (w[n/2-1] + w[n/2]) >>> 1;
		for (i = 0; i < 4; i++) begin
			dv[i] = abs_diff(r[i], med);
			mean16 += abs_diff(4 * r[i], sum);
		end
		for (i = 1; i < 4; i++) begin
			ut = dv[i];
			for (j = i; j > 0 && dv[j-1] > ut; j--) dv[j] = dv[j-1];
			dv[j] = ut;
		end
		mad2 = dv[1] + dv[2];
		pmed = longint'(thresh) * longint'(med_coeff);
		pmean = longint'(thresh) * longint'(mean_coeff);
		res.mask = '0;
		res.dead = dead[2:0];
		for (i = 0; i < 4; i++) begin
			ad = abs_diff(r[i], med);
			if (r[i] == 0) bad = 1'b1;
			else if (mad2 != 0) begin
				lhs = 128'(ad) << 25;
				rhs = 128'(pmed) * 128'(mad2);
				bad = lhs > rhs;
			end else if (mean16 != 0) begin
				lhs = 128'(ad) << 28;
				rhs = 128'(pmean) * 128'(mean16);
				bad = lhs > rhs;
			end else bad = 1'b0;
			res.cleaned[i] = bad ? med[31:0] : rd[i];
			if (!bad) res.mask[i] = 1'b1;
		end
		return res;
	endfunction

	// random set: mostly a tight cluster with the odd dead sensor or spike
	function automatic logic [3:0][31:0] random_set();
		logic [3:0][31:0] rd;
		logic [31:0]      base;
		int               spread, p, i;
		base = $urandom;
		spread = 1 << $urandom_range(0, 20);
		for (i = 0; i < 4; i++) begin
			p = $urandom_range(0, 39);
			if ($urandom_range(0, 9) == 0) rd[i] = $urandom;
			else if (p < 5) rd[i] = '0;
			else if (p == 5) rd[i] = 32'h7fffffff;
			else if (p == 6) rd[i] = 32'h80000000;
			else if (p < 10) rd[i] = base + $urandom;
			else rd[i] = base + $urandom_range(0, spread) - spread / 2;
		end
		return rd;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		case (idx)
			sor_pkg::REG_MED_COEFF:  med_coeff = val;
			sor_pkg::REG_MEAN_COEFF: mean_coeff = val;
			sor_pkg::REG_THRESHOLD:  thresh = val;
			default: ;     // outside the register list: ignored
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// one input transfer; the expectation is queued at acceptance
	task automatic send_set(logic [3:0][31:0] rd, bit typed, clean_set_t res);
		int gap;
		clean_set_t exp_set;
		@(negedge clk);
		s_tdata = rd;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		exp_set = typed ? res : clean_set(rd);
		pending_sets = {pending_sets, exp_set};
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (pending_sets.size() == 0);
		repeat (12) @(negedge clk);
	endtask

	// output side: random stalls, long ones now and then
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= pick_gap();
			m_tready <= 1'b0;
		end else m_tready <= 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		clean_set_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = clean_set_t'(m_tdata[134:0]);
			if (pending_sets.size() == 0) begin
				$error("result transfer with nothing expected");
				n_fail++;
			end else begin
				want = pending_sets.pop_front();
				for (int i = 0; i < 4; i++)
					if (got.cleaned[i] !== want.cleaned[i]) begin
						$error("cleaned_%0d exp %h got %h", i, want.cleaned[i], got.cleaned[i]);
						n_fail++;
					end
				if (got.mask !== want.mask) begin
					$error("reliable_mask exp %h got %h", want.mask, got.mask);
					n_fail++;
				end
				if (got.dead !== want.dead) begin
					$error("dead_count exp %0d got %0d", want.dead, got.dead);
					n_fail++;
				end
			end
		end
	end

	initial begin
		stim_row_t  dir_rows[$];
		stim_row_t  row;
		clean_set_t none;
		logic [15:0] cfg_sets[5][3];
		none = '0;
		// register settings per phase: reset values, zeros, maxima, two random
		cfg_sets[0] = '{sor_pkg::MED_COEFF_RST, sor_pkg::MEAN_COEFF_RST,
			sor_pkg::THRESHOLD_RST};
		cfg_sets[1] = '{16'h0000, 16'h0000, 16'h0000};
		cfg_sets[2] = '{16'hffff, 16'hffff, 16'hffff};
		cfg_sets[3] = '{16'($urandom), 16'($urandom), 16'($urandom)};
		cfg_sets[4] = '{16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
			16'($urandom_range(0, 8191))};

		// directed rows; the plain ones go through the predictor
		row = '0; row.typed = 1'b1; row.res.dead = 3'd4;               // all dead
		dir_rows = {dir_rows, row};
		row = '0; row.rd = {4{32'h0007_0000}}; row.typed = 1'b1;       // all equal
		row.res.cleaned = row.rd; row.res.mask = 4'hf;
		dir_rows = {dir_rows, row};
		row = '0; row.rd = {4{32'h7fffffff}}; row.typed = 1'b1;
		row.res.cleaned = row.rd; row.res.mask = 4'hf;
		dir_rows = {dir_rows, row};
		row = '0; row.rd = {4{32'h80000000}}; row.typed = 1'b1;
		row.res.cleaned = row.rd; row.res.mask = 4'hf;
		dir_rows = {dir_rows, row};
		row = '0;
		row.rd = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
		dir_rows = {dir_rows, row};
		row.rd = {32'h80000000, 32'h80000001, 32'h7ffffffe, 32'h7fffffff};
		dir_rows = {dir_rows, row};
		row.rd = {32'h0001_0000, 32'h0001_0010, 32'h0000_fff0, 32'h0009_0000}; // spike
		dir_rows = {dir_rows, row};
		row.rd = {32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0064_0000}; // MAD zero
		dir_rows = {dir_rows, row};
		row.rd = {32'h0, 32'h0003_0000, 32'h0003_0100, 32'h0002_ff00};  // one dead
		dir_rows = {dir_rows, row};
		row.rd = {32'h0, 32'hfff0_0000, 32'h0, 32'h0010_0000};          // two dead
		dir_rows = {dir_rows, row};
		row.rd = {32'h0, 32'h0, 32'hffff_ffff, 32'h0};                   // three dead
		dir_rows = {dir_rows, row};
		row.rd = {32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff};
		dir_rows = {dir_rows, row};
		row.rd = {32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001};
		dir_rows = {dir_rows, row};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				for (int k = 0; k < 3; k++) write_reg(k[1:0], cfg_sets[ph][k]);
				write_reg(2'd3, 16'($urandom));
				repeat (3) @(negedge clk);
			end
			foreach (dir_rows[i]) send_set(dir_rows[i].rd, dir_rows[i].typed,
				dir_rows[i].res);
			for (int n = 0; n < 340; n++) send_set(random_set(), 1'b0, none);
			drain();
		end

		repeat (20) @(posedge clk);
		if (n_fail == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/sor_pkg.sv
rtl/core/sor_median.sv
rtl/core/sor_dev.sv
rtl/core/sor_judge.sv
rtl/core/sensor_outlier_replacer.sv
verif/tb_top.sv
